[sv/dds_tfb_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the DDS tuning frame builder.
// No dependencies; used by every module of the block.
package dds_tfb_pkg;

    localparam int FREQ_W  = 32;
    localparam int AMP_W   = 12;
    localparam int MULT_W  = 24;
    localparam int FTW_W   = 48;
    localparam int BYTE_W  = 8;
    localparam int SWF_W   = 28;
    localparam int SWC_W   = 6;
    localparam int POS_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // request kinds carried on s_tuser
    localparam logic REQ_SET   = 1'b0;
    localparam logic REQ_SWEEP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MULT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUNE_INSTR  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_I_INSTR = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_AMP_Q_INSTR = 8'd3;

    localparam logic [MULT_W-1:0] FREQ_MULT_RST   = 24'd938250;
    localparam logic [BYTE_W-1:0] TUNE_INSTR_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] AMP_I_INSTR_RST = 8'd8;
    localparam logic [BYTE_W-1:0] AMP_Q_INSTR_RST = 8'd9;

    localparam logic [AMP_W-1:0] FULL_AMP = 12'd4095;

    // sweep schedule
    localparam logic [SWF_W-1:0] SWEEP_START = 28'd1;
    localparam logic [SWF_W-1:0] FREQ_CLAMP  = 28'd135000000;
    localparam logic [SWF_W-1:0] DEC_1K      = 28'd1000;
    localparam logic [SWF_W-1:0] DEC_10K     = 28'd10000;
    localparam logic [SWF_W-1:0] DEC_100K    = 28'd100000;
    localparam logic [SWF_W-1:0] DEC_1M      = 28'd1000000;
    localparam logic [SWF_W-1:0] DEC_10M     = 28'd10000000;
    localparam logic [SWF_W-1:0] STEP_1K     = 28'd199;
    localparam logic [SWF_W-1:0] STEP_10K    = 28'd2000;
    localparam logic [SWF_W-1:0] STEP_100K   = 28'd20000;
    localparam logic [SWF_W-1:0] STEP_1M     = 28'd200000;
    localparam logic [SWF_W-1:0] STEP_10M    = 28'd2000000;
    localparam logic [SWF_W-1:0] STEP_TOP    = 28'd5000000;

    // byte positions inside a frame
    localparam logic [POS_W-1:0] POS_TUNE_INSTR  = 4'd0;
    localparam logic [POS_W-1:0] POS_TW_FIRST    = 4'd1;
    localparam logic [POS_W-1:0] POS_TW_LAST     = 4'd6;
    localparam logic [POS_W-1:0] POS_AMP_I_INSTR = 4'd7;
    localparam logic [POS_W-1:0] POS_AMP_I_HI    = 4'd8;
    localparam logic [POS_W-1:0] POS_AMP_I_LO    = 4'd9;
    localparam logic [POS_W-1:0] POS_AMP_Q_INSTR = 4'd10;
    localparam logic [POS_W-1:0] POS_AMP_Q_HI    = 4'd11;
    localparam logic [POS_W-1:0] POS_AMP_Q_LO    = 4'd12;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [AMP_W-1:0]  amp;
    } job_t;

    typedef struct packed {
        logic [MULT_W-1:0] freq_mult;
        logic [BYTE_W-1:0] tune_instr;
        logic [BYTE_W-1:0] amp_i_instr;
        logic [BYTE_W-1:0] amp_q_instr;
    } cfg_t;

endpackage

[sv/dds_tfb_front.sv]
`timescale 1ns / 1ps
// Request intake: resolves set/sweep requests into a frequency/amplitude job
// and keeps the sweep state. Depends on dds_tfb_pkg.
module dds_tfb_front #(
    parameter int SWEEP_STEPS = 58
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,
    input  logic [0:0]                 s_tuser,
    input  logic                       q_full,
    output logic                       q_push,
    output dds_tfb_pkg::job_t          q_wdata
);

    logic [dds_tfb_pkg::SWF_W-1:0] sweep_freq_reg, sweep_freq_next;
    logic [dds_tfb_pkg::SWC_W-1:0] sweep_count_reg, sweep_count_next;
    logic [dds_tfb_pkg::SWF_W-1:0] step;
    logic [dds_tfb_pkg::SWF_W-1:0] stepped;
    logic [dds_tfb_pkg::SWC_W-1:0] count_inc;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb begin
        if (sweep_freq_reg < dds_tfb_pkg::DEC_1K) begin
            step = dds_tfb_pkg::STEP_1K;
        end else if (sweep_freq_reg < dds_tfb_pkg::DEC_10K) begin
            step = dds_tfb_pkg::STEP_10K;
        end else if (sweep_freq_reg < dds_tfb_pkg::DEC_100K) begin
            step = dds_tfb_pkg::STEP_100K;
        end else if (sweep_freq_reg < dds_tfb_pkg::DEC_1M) begin
            step = dds_tfb_pkg::STEP_1M;
        end else if (sweep_freq_reg < dds_tfb_pkg::DEC_10M) begin
            step = dds_tfb_pkg::STEP_10M;
        end else begin
            step = dds_tfb_pkg::STEP_TOP;
        end
        // sweep frequency never exceeds the clamp, so this sum fits in 28 bits
        stepped   = sweep_freq_reg + step;
        count_inc = sweep_count_reg + 1'b1;

        sweep_freq_next  = sweep_freq_reg;
        sweep_count_next = sweep_count_reg;
        if (q_push && (s_tuser[0] == dds_tfb_pkg::REQ_SWEEP)) begin
            if (count_inc >= dds_tfb_pkg::SWC_W'(SWEEP_STEPS)) begin
                sweep_count_next = '0;
                sweep_freq_next  = dds_tfb_pkg::SWEEP_START;
            end else begin
                sweep_count_next = count_inc;
                sweep_freq_next  = (stepped >= dds_tfb_pkg::FREQ_CLAMP) ?
                                   dds_tfb_pkg::FREQ_CLAMP : stepped;
            end
        end

        if (s_tuser[0] == dds_tfb_pkg::REQ_SWEEP) begin
            q_wdata.freq = dds_tfb_pkg::FREQ_W'(sweep_freq_reg);
            q_wdata.amp  = dds_tfb_pkg::FULL_AMP;
        end else begin
            q_wdata.freq = s_tdata[dds_tfb_pkg::FREQ_W-1:0];
            q_wdata.amp  = s_tdata[dds_tfb_pkg::FREQ_W +: dds_tfb_pkg::AMP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_freq_reg  <= dds_tfb_pkg::SWEEP_START;
            sweep_count_reg <= '0;
        end else begin
            sweep_freq_reg  <= sweep_freq_next;
            sweep_count_reg <= sweep_count_next;
        end
    end

endmodule

[sv/dds_tfb_queue.sv]
`timescale 1ns / 1ps
// Two-entry job queue between intake and frame serializer.
// Depends on dds_tfb_pkg.
module dds_tfb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  dds_tfb_pkg::job_t  wdata,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output dds_tfb_pkg::job_t  rdata
);

    dds_tfb_pkg::job_t                 mem_reg [dds_tfb_pkg::QUEUE_DEPTH];
    logic [dds_tfb_pkg::QPTR_W-1:0]    wptr_reg, rptr_reg;
    logic [dds_tfb_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == dds_tfb_pkg::QCNT_W'(dds_tfb_pkg::QUEUE_DEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = mem_reg[rptr_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !(pop && valid)) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (!push && pop && valid) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop && valid) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

endmodule

[sv/dds_tfb_back.sv]
`timescale 1ns / 1ps
// Frame engine: tuning word multiply stage, 13-byte serializer and output
// register. Depends on dds_tfb_pkg.
module dds_tfb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dds_tfb_pkg::cfg_t  cfg,
    input  logic               q_valid,
    input  dds_tfb_pkg::job_t  q_rdata,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);

    logic                              prod_valid_reg;
    logic [dds_tfb_pkg::FTW_W-1:0]     prod_ftw_reg;
    logic [dds_tfb_pkg::AMP_W-1:0]     prod_amp_reg;
    logic [dds_tfb_pkg::FREQ_W+dds_tfb_pkg::MULT_W-1:0] product;

    logic                              frame_valid_reg;
    logic [dds_tfb_pkg::POS_W-1:0]     pos_reg;
    logic [dds_tfb_pkg::FTW_W-1:0]     ftw_reg;
    logic [dds_tfb_pkg::AMP_W-1:0]     amp_reg;

    logic                              out_valid_reg;
    logic [dds_tfb_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                              out_last_reg;

    logic                              advance;
    logic                              at_last;
    logic                              frame_load;
    logic                              prod_take;
    logic [dds_tfb_pkg::BYTE_W-1:0]    cur_byte;
    logic [dds_tfb_pkg::BYTE_W-1:0]    amp_hi;

    assign advance    = frame_valid_reg && (!out_valid_reg || m_tready);
    assign at_last    = (pos_reg == dds_tfb_pkg::POS_AMP_Q_LO);
    assign frame_load = !frame_valid_reg || (advance && at_last);
    assign prod_take  = prod_valid_reg && frame_load;
    assign q_pop      = q_valid && (!prod_valid_reg || prod_take);
    assign product    = q_rdata.freq * cfg.freq_mult;
    assign amp_hi     = {4'b0, amp_reg[dds_tfb_pkg::AMP_W-1:8]};

    always_comb begin
        case (pos_reg) inside
            dds_tfb_pkg::POS_TUNE_INSTR:
                cur_byte = cfg.tune_instr;
            [dds_tfb_pkg::POS_TW_FIRST:dds_tfb_pkg::POS_TW_LAST]:
                cur_byte = ftw_reg[dds_tfb_pkg::FTW_W-1 -: dds_tfb_pkg::BYTE_W];
            dds_tfb_pkg::POS_AMP_I_INSTR:
                cur_byte = cfg.amp_i_instr;
            dds_tfb_pkg::POS_AMP_Q_INSTR:
                cur_byte = cfg.amp_q_instr;
            dds_tfb_pkg::POS_AMP_I_HI, dds_tfb_pkg::POS_AMP_Q_HI:
                cur_byte = amp_hi;
            dds_tfb_pkg::POS_AMP_I_LO, dds_tfb_pkg::POS_AMP_Q_LO:
                cur_byte = amp_reg[7:0];
            default:
                cur_byte = '0;
        endcase
    end

    // payload
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            prod_ftw_reg <= product[dds_tfb_pkg::FTW_W-1:0];
            prod_amp_reg <= q_rdata.amp;
        end
        if (frame_load) begin
            ftw_reg <= prod_ftw_reg;
            amp_reg <= prod_amp_reg;
        end else if (advance && (pos_reg >= dds_tfb_pkg::POS_TW_FIRST)
                     && (pos_reg <= dds_tfb_pkg::POS_TW_LAST)) begin
            // tuning word goes out MSB first: shift the next byte up
            ftw_reg <= {ftw_reg[dds_tfb_pkg::FTW_W-dds_tfb_pkg::BYTE_W-1:0],
                        {dds_tfb_pkg::BYTE_W{1'b0}}};
        end
        if (advance) begin
            out_byte_reg <= cur_byte;
            out_last_reg <= at_last;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg  <= 1'b0;
            frame_valid_reg <= 1'b0;
            pos_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                prod_valid_reg <= 1'b1;
            end else if (prod_take) begin
                prod_valid_reg <= 1'b0;
            end

            if (frame_load) begin
                frame_valid_reg <= prod_valid_reg;
                pos_reg         <= dds_tfb_pkg::POS_TUNE_INSTR;
            end else if (advance) begin
                pos_reg <= pos_reg + 1'b1;
            end

            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

[sv/dds_tuning_frame_builder.sv]
`timescale 1ns / 1ps
// DDS tuning frame builder top level: config registers, intake, job queue
// and frame engine. Depends on dds_tfb_pkg and the dds_tfb_* modules.
// Path: a request passes the queue, product register, frame register and output register in order.
// Throughput: one byte beat per cycle on m_ while m_tready is high;
// the output byte serializer sets the pace. Up to two requests queue ahead.
// Reset (aresetn low, synchronous): registers to defaults, sweep to 1 Hz.
module dds_tuning_frame_builder #(
    parameter int SWEEP_STEPS = 58
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // [31:0] frequency_hz, [43:32] amplitude, rest zero
    input  logic [0:0]  s_tuser,    // [0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // frame_last
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    dds_tfb_pkg::cfg_t cfg_reg;
    dds_tfb_pkg::job_t q_wdata, q_rdata;
    logic q_push, q_full, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.freq_mult   <= dds_tfb_pkg::FREQ_MULT_RST;
            cfg_reg.tune_instr  <= dds_tfb_pkg::TUNE_INSTR_RST;
            cfg_reg.amp_i_instr <= dds_tfb_pkg::AMP_I_INSTR_RST;
            cfg_reg.amp_q_instr <= dds_tfb_pkg::AMP_Q_INSTR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dds_tfb_pkg::CFG_FREQ_MULT:   cfg_reg.freq_mult   <= cfg_wdata;
                dds_tfb_pkg::CFG_TUNE_INSTR:  cfg_reg.tune_instr  <= cfg_wdata[7:0];
                dds_tfb_pkg::CFG_AMP_I_INSTR: cfg_reg.amp_i_instr <= cfg_wdata[7:0];
                dds_tfb_pkg::CFG_AMP_Q_INSTR: cfg_reg.amp_q_instr <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    dds_tfb_front #(
        .SWEEP_STEPS(SWEEP_STEPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    dds_tfb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .rdata   (q_rdata)
    );

    dds_tfb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_rdata  (q_rdata),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
